>>> design/assert_macros.svh
// shared assertion macros for the slot allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define NFSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define NFSA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> design/nfsa_pkg.sv
`default_nettype none

package nfsa_pkg;

  localparam int POOL_SLOTS  = 64;
  localparam int SLOT_W      = 6;
  localparam int COUNT_W     = 7;
  localparam int CHUNK       = 16;
  localparam int CHUNK_W     = 4;
  localparam int NUM_CHUNKS  = POOL_SLOTS / CHUNK;
  localparam int CHUNK_SEL_W = 2;
  localparam int STEP_W      = 3;

  // last scan step revisits the start chunk below the pointer
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_CHUNKS);

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_FULL        = 2'd1;
  localparam logic [1:0] STATUS_DOUBLE_FREE = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot_to_free;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  granted_slot;
    logic [1:0]         status;
    logic [COUNT_W-1:0] available;
    logic [COUNT_W-1:0] peak_used;
  } rsp_t;

  typedef struct packed {
    logic              load_req;
    logic [STEP_W-1:0] step;
    logic              commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic kind;
    logic full;
    logic hit;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> design/nfsa_controller.sv
`default_nettype none

module nfsa_controller (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire nfsa_pkg::dp_sts_t  sts,
  output nfsa_pkg::ctl_cmd_t      cmd
);

`include "assert_macros.svh"

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                        state;
  logic                        state_next;
  logic [nfsa_pkg::STEP_W-1:0] step;
  logic [nfsa_pkg::STEP_W-1:0] step_next;
  logic                        out_valid_next;
  logic                        accept;
  logic                        done;
  logic                        out_room;
  logic                        commit;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign done     = (sts.kind == nfsa_pkg::KIND_RELEASE) || sts.full || sts.hit;
  assign out_room = !out_valid || !out_stall;
  assign commit   = (state == ST_RUN) && done && out_room;

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
          step_next  = '0;
        end
      end
      ST_RUN: begin
        if (commit) begin
          state_next = ST_IDLE;
        end else if (!done && step != nfsa_pkg::LAST_STEP) begin
          step_next = step + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (commit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  assign cmd.load_req = accept;
  assign cmd.step     = step;
  assign cmd.commit   = commit;

  // a pending allocate finds a slot or sees a full pool by the wrap-around step
  `NFSA_ASSERT_IMPL(a_scan_ends, (state == ST_RUN) && (step == nfsa_pkg::LAST_STEP), done, "scan ran past last chunk")
  // a committed beat shows up on the output next cycle
  `NFSA_ASSERT(a_commit_shows, commit |=> out_valid, "committed result not presented")
  // scan step never leaves its range
  `NFSA_ASSERT(a_step_range, step <= nfsa_pkg::LAST_STEP, "scan step out of range")

endmodule

`default_nettype wire

>>> design/nfsa_datapath.sv
`default_nettype none

module nfsa_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire nfsa_pkg::ctl_cmd_t cmd,
  input  wire nfsa_pkg::req_t     in_data,
  output nfsa_pkg::dp_sts_t       sts,
  output nfsa_pkg::rsp_t          out_data
);

`include "assert_macros.svh"

  logic [nfsa_pkg::POOL_SLOTS-1:0]  slot_free;
  logic [nfsa_pkg::SLOT_W-1:0]      search_pointer;
  logic [nfsa_pkg::COUNT_W-1:0]     free_count;
  logic [nfsa_pkg::COUNT_W-1:0]     peak_busy;
  nfsa_pkg::req_t                   req;
  nfsa_pkg::rsp_t                   rsp;
  nfsa_pkg::rsp_t                   rsp_next;

  logic [nfsa_pkg::CHUNK_SEL_W-1:0] chunk_sel;
  logic [nfsa_pkg::CHUNK-1:0]       chunk_bits;
  logic [nfsa_pkg::CHUNK-1:0]       start_mask;
  logic [nfsa_pkg::CHUNK-1:0]       cand;
  logic                             hit;
  logic [nfsa_pkg::CHUNK_W-1:0]     hit_pos;
  logic [nfsa_pkg::SLOT_W-1:0]      hit_slot;
  logic                             full;
  logic                             release_bad;
  logic [nfsa_pkg::COUNT_W-1:0]     busy_after;

  // chunk under test: pointer chunk plus step, last step wraps to the start chunk
  assign chunk_sel  = search_pointer[nfsa_pkg::SLOT_W-1:nfsa_pkg::CHUNK_W]
                    + cmd.step[nfsa_pkg::CHUNK_SEL_W-1:0];
  assign chunk_bits = slot_free[{chunk_sel, {nfsa_pkg::CHUNK_W{1'b0}}} +: nfsa_pkg::CHUNK];
  assign start_mask = {nfsa_pkg::CHUNK{1'b1}} << search_pointer[nfsa_pkg::CHUNK_W-1:0];
  assign cand       = (cmd.step == '0) ? (chunk_bits & start_mask) : chunk_bits;

  // lowest free slot in the chunk
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = nfsa_pkg::CHUNK - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit     = 1'b1;
        hit_pos = nfsa_pkg::CHUNK_W'(i);
      end
    end
  end

  assign hit_slot    = {chunk_sel, hit_pos};
  assign full        = (free_count == '0);
  assign release_bad = slot_free[req.slot_to_free];
  assign busy_after  = nfsa_pkg::COUNT_W'(nfsa_pkg::POOL_SLOTS) - free_count + 1'b1;

  assign sts.kind = req.kind;
  assign sts.full = full;
  assign sts.hit  = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_free      <= '1;
      search_pointer <= '0;
      free_count     <= nfsa_pkg::COUNT_W'(nfsa_pkg::POOL_SLOTS);
      peak_busy      <= '0;
    end else if (cmd.commit) begin
      if (req.kind == nfsa_pkg::KIND_ALLOC) begin
        if (!full) begin
          slot_free[hit_slot] <= 1'b0;
          free_count          <= free_count - 1'b1;
          search_pointer      <= hit_slot + 1'b1;
          if (busy_after > peak_busy) begin
            peak_busy <= busy_after;
          end
        end
      end else if (!release_bad) begin
        slot_free[req.slot_to_free] <= 1'b1;
        free_count                  <= free_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= in_data;
    end
  end

  // result as the state stands after the commit
  always_comb begin
    rsp_next.granted_slot = '0;
    rsp_next.status       = nfsa_pkg::STATUS_OK;
    rsp_next.available    = free_count;
    rsp_next.peak_used    = peak_busy;
    if (req.kind == nfsa_pkg::KIND_ALLOC) begin
      if (full) begin
        rsp_next.status = nfsa_pkg::STATUS_FULL;
      end else begin
        rsp_next.granted_slot = hit_slot;
        rsp_next.available    = free_count - 1'b1;
        if (busy_after > peak_busy) begin
          rsp_next.peak_used = busy_after;
        end
      end
    end else if (release_bad) begin
      rsp_next.status = nfsa_pkg::STATUS_DOUBLE_FREE;
    end else begin
      rsp_next.available = free_count + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

  assign out_data = rsp;

  // count always matches the bitmap
  `NFSA_ASSERT(a_count_match, $countones(slot_free) == free_count, "free count out of step with bitmap")
  // peak never below the busy slots now held
  `NFSA_ASSERT(a_peak_floor, ((nfsa_pkg::COUNT_W+1)'(peak_busy) + free_count) >= (nfsa_pkg::COUNT_W+1)'(nfsa_pkg::POOL_SLOTS), "peak below current usage")
  // an allocate committed with room left has found a slot
  `NFSA_ASSERT_IMPL(a_alloc_hit, cmd.commit && (req.kind == nfsa_pkg::KIND_ALLOC) && !full, hit, "allocate committed without a slot")

endmodule

`default_nettype wire

>>> design/next_fit_slot_allocator_top.sv
// a release or a full-pool allocate is decided at the first scan step; an allocate scans
//   one 16-slot chunk of the free bitmap per cycle, up to 5 steps, until a free slot is found
// one request in flight; the next beat is taken the cycle after a result is
//   registered, and a result is committed only when the result register has room
// reset (rst, synchronous, active high): every slot free, search pointer zero,
//   available count at pool size, peak zero; no clearing pass
`default_nettype none

module next_fit_slot_allocator_top (
  input  wire logic           clk,
  input  wire logic           rst,
  // request beats
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire nfsa_pkg::req_t in_data,
  // result beats
  output logic                out_valid,
  input  wire logic           out_stall,
  output nfsa_pkg::rsp_t      out_data
);

  // command and status between sequencer and datapath
  nfsa_pkg::ctl_cmd_t cmd;
  nfsa_pkg::dp_sts_t  sts;

  // sequencer: takes a beat, steps the chunk scan, commits when the result register has room
  nfsa_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: free bitmap, search pointer, counts, chunk search and result register
  nfsa_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
